/* rtl/bmf_pkg.sv */
package bmf_pkg;

  // Fixed field widths of the item and register interface
  localparam int unsigned CoordW  = 8;
  localparam int unsigned PixW    = 8;
  localparam int unsigned DimW    = 9;
  localparam int unsigned KernW   = 4;
  localparam int unsigned CfgIdxW = 2;

  // Default storage limits
  localparam int unsigned DefMaxWidth  = 256;
  localparam int unsigned DefMaxHeight = 256;
  localparam int unsigned DefMaxKernel = 15;

  // Register reset values
  localparam logic [DimW-1:0]  FrameDimRst = 9'd256;
  localparam logic [KernW-1:0] KernRst     = 4'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgKernelSize  = 2'd2;

  typedef struct packed {
    logic load;       // latch the item and the register snapshot
    logic finish;     // short result: write or outside-frame item
    logic store;      // write the pixel into the frame store
    logic scan_init;  // reset window walker, sum and quotient
    logic scan_step;  // fetch one window pixel, advance walker
    logic div_step;   // one restoring-division step
  } bmf_cmd_t;

  typedef struct packed {
    logic in_frame;
    logic is_read;
    logic scan_last;
    logic div_last;
  } bmf_sts_t;

  // Zero reads as one, anything above the limit saturates to it
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v,
                                                input int unsigned maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > maxv) begin
      r = DimW'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

/* rtl/bmf_ctrl.sv */
module bmf_ctrl
  import bmf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  bmf_sts_t sts_i,
  output bmf_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIVIDE
  } state_e;

  state_e state_q;
  logic   done_q;

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
      end
      ST_DECIDE: begin
        if (!sts_i.in_frame || !sts_i.is_read) begin
          cmd_o.finish = 1'b1;
          cmd_o.store  = sts_i.in_frame && !sts_i.is_read;
        end else begin
          cmd_o.scan_init = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      ST_DRAIN: begin
        cmd_o = '0;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!sts_i.in_frame || !sts_i.is_read) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end else begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (sts_i.scan_last) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state_q <= ST_DIVIDE;
        end
        ST_DIVIDE: begin
          if (sts_i.div_last) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

/* rtl/bmf_dpath.sv */
module bmf_dpath
  import bmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight,
  parameter int unsigned MAX_KERNEL = DefMaxKernel
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bmf_cmd_t          cmd_i,
  output bmf_sts_t          sts_o,
  input  logic              func_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [CoordW-1:0] col_i,
  input  logic [PixW-1:0]   pixel_in_i,
  input  logic [DimW-1:0]   frame_width_i,
  input  logic [DimW-1:0]   frame_height_i,
  input  logic [KernW-1:0]  kernel_size_i,
  output logic [PixW-1:0]   mean_value_o,
  output logic              status_o
);

  localparam int unsigned KernRegMax = (2 ** KernW) - 1;
  localparam int unsigned KernCap    = (MAX_KERNEL < KernRegMax) ? MAX_KERNEL : KernRegMax;
  localparam int unsigned OffMax     = KernCap / 2;
  localparam int unsigned OffW       = $clog2(OffMax + 2);
  localparam int unsigned SideMax    = 2 * OffMax + 1;
  localparam int unsigned AreaMax    = SideMax * SideMax;
  localparam int unsigned AreaW      = $clog2(AreaMax + 1);
  localparam int unsigned SumW       = AreaW + PixW;
  localparam int unsigned Depth      = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AddrW      = $clog2(Depth);
  localparam int unsigned NbW        = DimW + 1;
  localparam int unsigned BitW       = $clog2(PixW);

  localparam logic signed [OffW:0] OneS = (OffW + 1)'(1);

  // Item snapshot
  logic              func_q;
  logic [CoordW-1:0] row_q;
  logic [CoordW-1:0] col_q;
  logic [PixW-1:0]   pix_q;
  logic [DimW-1:0]   w_q;
  logic [DimW-1:0]   h_q;
  logic [OffW-1:0]   off_q;
  logic [AreaW-1:0]  area_q;

  // Window walker, accumulator and divider
  logic signed [OffW:0] dy_q;
  logic signed [OffW:0] dx_q;
  logic                 rd_pend_q;
  logic [PixW-1:0]      rdata_q;
  logic [SumW-1:0]      sum_q;
  logic [PixW-1:0]      mean_q;
  logic                 status_q;
  logic [BitW-1:0]      bit_q;

  logic [PixW-1:0]      mem [Depth];

  logic [KernW-1:0]       k_eff;
  logic [OffW-1:0]        off_d;
  logic [OffW:0]          side_d;
  logic [2*OffW+1:0]      area_full;
  logic signed [OffW:0]   off_s;
  logic signed [NbW-1:0]  ny;
  logic signed [NbW-1:0]  nx;
  logic                   inb;
  logic [AddrW-1:0]       rd_addr;
  logic [AddrW-1:0]       wr_addr;
  logic [SumW-1:0]        trial;

  assign k_eff     = (32'(kernel_size_i) > KernCap) ? KernW'(KernCap) : kernel_size_i;
  assign off_d     = OffW'(k_eff >> 1);
  assign side_d    = {off_d, 1'b1};
  assign area_full = side_d * side_d;

  assign off_s = $signed({1'b0, off_q});
  assign ny    = $signed({2'b00, row_q}) + NbW'(dy_q);
  assign nx    = $signed({2'b00, col_q}) + NbW'(dx_q);
  assign inb   = !ny[NbW-1] && (ny < $signed({1'b0, h_q})) &&
                 !nx[NbW-1] && (nx < $signed({1'b0, w_q}));

  assign rd_addr = AddrW'(ny[DimW-1:0]) * AddrW'(MAX_WIDTH) + AddrW'(nx[DimW-1:0]);
  assign wr_addr = AddrW'(row_q) * AddrW'(MAX_WIDTH) + AddrW'(col_q);

  assign trial = SumW'(area_q) << bit_q;

  assign sts_o.in_frame  = (DimW'(row_q) < h_q) && (DimW'(col_q) < w_q);
  assign sts_o.is_read   = func_q;
  assign sts_o.scan_last = (dx_q == off_s) && (dy_q == off_s);
  assign sts_o.div_last  = (bit_q == '0);

  // Latch the item with the register values it runs under
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= func_i;
      row_q  <= row_i;
      col_q  <= col_i;
      pix_q  <= pixel_in_i;
      w_q    <= clamp_dim(frame_width_i, MAX_WIDTH);
      h_q    <= clamp_dim(frame_height_i, MAX_HEIGHT);
      off_q  <= off_d;
      area_q <= AreaW'(area_full);
    end
  end

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem[wr_addr] <= pix_q;
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      dy_q <= -off_s;
      dx_q <= -off_s;
    end else if (cmd_i.scan_step) begin
      if (dx_q == off_s) begin
        dx_q <= -off_s;
        dy_q <= dy_q + OneS;
      end else begin
        dx_q <= dx_q + OneS;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_init) begin
      sum_q <= '0;
      bit_q <= BitW'(PixW - 1);
    end else if (cmd_i.div_step) begin
      if (sum_q >= trial) sum_q <= sum_q - trial;
      bit_q <= bit_q - BitW'(1);
    end else if (rd_pend_q) begin
      sum_q <= sum_q + SumW'(rdata_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
      mean_q    <= '0;
      status_q  <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.scan_step && inb;
      if (cmd_i.finish) begin
        mean_q   <= '0;
        status_q <= !sts_o.in_frame;
      end else if (cmd_i.scan_init) begin
        mean_q   <= '0;
        status_q <= 1'b0;
      end else if (cmd_i.div_step) begin
        mean_q[bit_q] <= (sum_q >= trial);
      end
    end
  end

  assign mean_value_o = mean_q;
  assign status_o     = status_q;

endmodule

/* rtl/box_mean_filter_zero_pad.sv */
// Box mean filter with zero padding over an 8-bit frame store. Raise start_i
// while busy_o is low to hand in an item: func_i = 0 stores pixel_in_i at
// (row_i, col_i), func_i = 1 reads the mean of the square window centred on
// (row_i, col_i), side 2*floor(k/2)+1. Pixels outside the frame add zero but
// still count in the divisor; the quotient is truncated. Every item gives one
// result: done_o is high for exactly one cycle with mean_value_o and status_o,
// and the receiver cannot stall it, so take it in that cycle. status_o = 1
// flags a coordinate outside the frame (mean 0, write dropped). A write or
// an outside-frame item finishes straight from the decide state. A read
// walks the window one pixel per cycle through the single read port of the
// frame store, drains the last read, then an 8-step restoring divider
// produces the mean; the largest window is 15x15 by default. busy_o drops
// in the cycle done_o is high, so the next item may start there. The frame store
// is not cleared at reset; reading a pixel never written gives an undefined
// mean. Write registers only while busy_o is low and no result is pending.
module box_mean_filter_zero_pad
  import bmf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight,
  parameter int unsigned MAX_KERNEL = DefMaxKernel
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item channel
  input  logic               start_i,
  output logic               busy_o,
  input  logic               func_i,
  input  logic [CoordW-1:0]  row_i,
  input  logic [CoordW-1:0]  col_i,
  input  logic [PixW-1:0]    pixel_in_i,
  // result channel
  output logic               done_o,
  output logic [PixW-1:0]    mean_value_o,
  output logic               status_o,
  // register write port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DimW-1:0]    cfg_data_i
);

  logic [DimW-1:0]  frame_width_q;
  logic [DimW-1:0]  frame_height_q;
  logic [KernW-1:0] kernel_size_q;

  bmf_cmd_t cmd;
  bmf_sts_t sts;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameDimRst;
      frame_height_q <= FrameDimRst;
      kernel_size_q  <= KernRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgFrameWidth:  frame_width_q  <= cfg_data_i;
        CfgFrameHeight: frame_height_q <= cfg_data_i;
        CfgKernelSize:  kernel_size_q  <= cfg_data_i[KernW-1:0];
        default: begin
          frame_width_q <= frame_width_q;
        end
      endcase
    end
  end

  // Sequencer: accept, decide, walk window, drain read, divide
  bmf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o),
    .done_o  (done_o)
  );

  // Frame store, window walker, accumulator and divider
  bmf_dpath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .func_i         (func_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .pixel_in_i     (pixel_in_i),
    .frame_width_i  (frame_width_q),
    .frame_height_i (frame_height_q),
    .kernel_size_i  (kernel_size_q),
    .mean_value_o   (mean_value_o),
    .status_o       (status_o)
  );

  // A result always lands with the sequencer back in idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while busy");

  // An accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted item did not start");

  // Outside-frame results carry a zero mean
  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o) |-> (mean_value_o == '0))
    else $error("nonzero mean on outside-frame result");

  // One strobe per item, never two in a row
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("repeated result strobe");

endmodule
